// ----- rtl/dqnp_pkg.sv -----
package dqnp_pkg;

  // Parser phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LENGTH = 3'd1;
  localparam logic [2:0] PH_BODY   = 3'd2;
  localparam logic [2:0] PH_TAIL   = 3'd3;
  localparam logic [2:0] PH_IGNORE = 3'd4;

  // Verdict status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_NOQ        = 3'd2;
  localparam logic [2:0] ST_PTR        = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  // Result kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Protocol constants
  localparam logic [3:0] HDR_LAST_IDX = 4'd11;
  localparam logic [3:0] HDR_QD_HI    = 4'd4;
  localparam logic [3:0] HDR_QD_LO    = 4'd5;
  localparam logic [7:0] PTR_MASK     = 8'hC0;
  localparam logic [2:0] TAIL_BYTES   = 3'd4;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic [2:0]  status;
    logic [15:0] rr_type;
    logic [7:0]  name_length;
  } dqnp_result_t;

endpackage

// ----- rtl/dqnp_if.sv -----
// Byte input channel
interface dqnp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result output channel
interface dqnp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_char;
  logic [2:0]  status;
  logic [15:0] rr_type;
  logic [7:0]  name_length;

  modport source (output valid, output kind, output name_char, output status,
                  output rr_type, output name_length, input ready);
  modport sink (input valid, input kind, input name_char, input status,
                input rr_type, input name_length, output ready);
endinterface

// ----- rtl/dqnp_parser.sv -----
module dqnp_parser import dqnp_pkg::*; #(
  parameter int NAME_CAPACITY = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_byte_i,
  output logic         emit_o,
  output dqnp_result_t result_o
);

  localparam logic [8:0] NameLimit = 9'(NAME_CAPACITY - 1);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  count_high_q, count_high_d;
  logic [7:0]  label_rem_q, label_rem_d;
  logic [7:0]  name_count_q, name_count_d;
  logic [2:0]  tail_idx_q, tail_idx_d;
  logic [15:0] type_q, type_d;
  logic [2:0]  err_q, err_d;
  logic        room;
  logic [2:0]  verdict;

  assign room = {1'b0, name_count_q} < NameLimit;

  // Per-byte state update and result selection
  always_comb begin
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    count_high_d = count_high_q;
    label_rem_d  = label_rem_q;
    name_count_d = name_count_q;
    tail_idx_d   = tail_idx_q;
    type_d       = type_q;
    err_d        = err_q;
    emit_o       = 1'b0;
    result_o     = '0;
    verdict      = ST_OK;

    case (phase_q)
      PH_HEADER: begin
        if (hdr_idx_q == HDR_QD_HI) begin
          count_high_d = data_byte_i;
        end else if (hdr_idx_q == HDR_QD_LO) begin
          count_high_d = count_high_q | data_byte_i;
        end
        if (hdr_idx_q >= HDR_LAST_IDX) begin
          if (count_high_q == '0) begin
            err_d   = ST_NOQ;
            phase_d = PH_IGNORE;
          end else begin
            phase_d = PH_LENGTH;
          end
        end else begin
          hdr_idx_d = hdr_idx_q + 4'd1;
        end
      end
      PH_LENGTH: begin
        if (data_byte_i == '0) begin
          phase_d    = PH_TAIL;
          tail_idx_d = '0;
        end else if ((data_byte_i & PTR_MASK) == PTR_MASK) begin
          err_d   = ST_PTR;
          phase_d = PH_IGNORE;
        end else begin
          label_rem_d = data_byte_i;
          phase_d     = PH_BODY;
          // dot between labels
          if (name_count_q != '0 && room) begin
            name_count_d       = name_count_q + 8'd1;
            emit_o             = 1'b1;
            result_o.name_char = DOT_CHAR;
          end
        end
      end
      PH_BODY: begin
        if (room) begin
          name_count_d       = name_count_q + 8'd1;
          emit_o             = 1'b1;
          result_o.name_char = data_byte_i;
        end
        label_rem_d = label_rem_q - 8'd1;
        if (label_rem_d == '0) begin
          phase_d = PH_LENGTH;
        end
      end
      PH_TAIL: begin
        if (tail_idx_q == 3'd0) begin
          type_d = {data_byte_i, 8'h00};
        end else if (tail_idx_q == 3'd1) begin
          type_d = {type_q[15:8], data_byte_i};
        end
        if (tail_idx_q < TAIL_BYTES) begin
          tail_idx_d = tail_idx_q + 3'd1;
        end
      end
      default: ;
    endcase

    // Final byte: verdict replaces any character, state back to reset
    if (last_byte_i) begin
      if (err_d != ST_OK) begin
        verdict = err_d;
      end else if (phase_d == PH_HEADER) begin
        verdict = ST_SHORT;
      end else if (phase_d == PH_TAIL && tail_idx_d >= TAIL_BYTES) begin
        verdict = ST_OK;
      end else begin
        verdict = ST_INCOMPLETE;
      end
      emit_o          = 1'b1;
      result_o        = '0;
      result_o.kind   = KIND_VERDICT;
      result_o.status = verdict;
      if (verdict == ST_OK) begin
        result_o.rr_type     = type_d;
        result_o.name_length = name_count_d;
      end
      phase_d      = PH_HEADER;
      hdr_idx_d    = '0;
      count_high_d = '0;
      label_rem_d  = '0;
      name_count_d = '0;
      tail_idx_d   = '0;
      type_d       = '0;
      err_d        = ST_OK;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      hdr_idx_q    <= '0;
      count_high_q <= '0;
      label_rem_q  <= '0;
      name_count_q <= '0;
      tail_idx_q   <= '0;
      type_q       <= '0;
      err_q        <= ST_OK;
    end else if (step_i) begin
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      count_high_q <= count_high_d;
      label_rem_q  <= label_rem_d;
      name_count_q <= name_count_d;
      tail_idx_q   <= tail_idx_d;
      type_q       <= type_d;
      err_q        <= err_d;
    end
  end

  // A final byte always leaves the parser in its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_byte_i |=> phase_q == PH_HEADER && name_count_q == '0 && err_q == ST_OK)
    else $error("parser state not cleared after final byte");

  // Kept name never exceeds the capacity limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, name_count_q} <= NameLimit)
    else $error("name count beyond capacity");

  // A character result only comes with a body or length byte while there is room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && !last_byte_i |-> (phase_q == PH_BODY || phase_q == PH_LENGTH) && room)
    else $error("character emitted outside name walk");

endmodule

// ----- rtl/dqnp_out_stage.sv -----
module dqnp_out_stage import dqnp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  dqnp_result_t result_i,
  input  logic         ready_i,
  output logic         free_o,
  output logic         valid_o,
  output dqnp_result_t result_o
);

  logic         valid_q;
  dqnp_result_t data_q;

  // Register may take a new result when empty or being drained
  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= result_i;
    end
  end

endmodule

// ----- rtl/dns_query_name_parser_top.sv -----
// A result passes through the input register and then the output register on its way out.
// Throughput: one byte per cycle while the output is not backpressured; the parser state updates once per byte.
// Backpressure on the output stalls the input register and the parser in step.
// Reset (rst_ni, asynchronous, active low) empties both registers and returns
// the parser to the header phase with all counters cleared.
module dns_query_name_parser_top import dqnp_pkg::*; #(
  parameter int NAME_CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dqnp_in_if.sink     in_i,
  dqnp_out_if.source  out_o
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         pipe_free;
  logic         step;
  logic         emit;
  dqnp_result_t result;
  dqnp_result_t out_result;

  assign in_i.ready = !in_valid_q || pipe_free;
  assign step       = in_valid_q && pipe_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  dqnp_parser #(
    .NAME_CAPACITY(NAME_CAPACITY)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .emit_o      (emit),
    .result_o    (result)
  );

  dqnp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && emit),
    .result_i (result),
    .ready_i  (out_o.ready),
    .free_o   (pipe_free),
    .valid_o  (out_o.valid),
    .result_o (out_result)
  );

  assign out_o.kind        = out_result.kind;
  assign out_o.name_char   = out_result.name_char;
  assign out_o.status      = out_result.status;
  assign out_o.rr_type     = out_result.rr_type;
  assign out_o.name_length = out_result.name_length;

endmodule

// ----- sim/tb_dns_query_name_parser_top.sv -----
`timescale 1ns / 100ps

module tb_dns_query_name_parser_top import dqnp_pkg::*; ();

  localparam int NAME_CAPACITY = 256;
  localparam int IDLE_LIMIT    = 3000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_BYTES  = 380;

  logic clk_i = 1'b0;
  logic rst_ni;

  dqnp_in_if  in_bus ();
  dqnp_out_if out_bus ();

  dns_query_name_parser_top #(
    .NAME_CAPACITY(NAME_CAPACITY)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #6 clk_i = ~clk_i;

  // Mirror of the parser state
  logic [2:0]  walk_phase;
  logic [3:0]  hdr_pos;
  logic [7:0]  qd_mark;
  logic [7:0]  label_left;
  logic [7:0]  chars_kept;
  logic [2:0]  tail_pos;
  logic [15:0] qtype_word;
  logic [2:0]  verdict_err;

  dqnp_result_t pending_results[$];
  dqnp_result_t got_res;
  dqnp_result_t want_res;

  logic [7:0] pkt_bytes[$];

  int mismatches = 0;
  int idle_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int rx_hold_len = 0;

  task automatic clear_parse_state();
    walk_phase  = PH_HEADER;
    hdr_pos     = '0;
    qd_mark     = '0;
    label_left  = '0;
    chars_kept  = '0;
    tail_pos    = '0;
    qtype_word  = '0;
    verdict_err = ST_OK;
  endtask

  // Counts a name character if there is still room for it
  function automatic bit take_char();
    if (int'(chars_kept) < NAME_CAPACITY - 1) begin
      chars_kept = chars_kept + 8'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the mirror by one byte and queue the result it causes
  task automatic parse_byte(input logic [7:0] b, input logic is_last);
    bit           emit;
    logic [7:0]   ch;
    logic [2:0]   st;
    dqnp_result_t res;
    emit = 1'b0;
    ch   = '0;
    case (walk_phase)
      PH_HEADER: begin
        if (hdr_pos == HDR_QD_HI) qd_mark = b;
        else if (hdr_pos == HDR_QD_LO) qd_mark = qd_mark | b;
        if (hdr_pos >= HDR_LAST_IDX) begin
          if (qd_mark == 8'd0) begin
            verdict_err = ST_NOQ;
            walk_phase  = PH_IGNORE;
          end else begin
            walk_phase = PH_LENGTH;
          end
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end
      PH_LENGTH: begin
        if (b == 8'd0) begin
          walk_phase = PH_TAIL;
          tail_pos   = '0;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          verdict_err = ST_PTR;
          walk_phase  = PH_IGNORE;
        end else begin
          label_left = b;
          walk_phase = PH_BODY;
          if (chars_kept != 8'd0 && take_char()) begin
            emit = 1'b1;
            ch   = DOT_CHAR;
          end
        end
      end
      PH_BODY: begin
        if (take_char()) begin
          emit = 1'b1;
          ch   = b;
        end
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) walk_phase = PH_LENGTH;
      end
      PH_TAIL: begin
        if (tail_pos == 3'd0) qtype_word = {b, 8'h00};
        else if (tail_pos == 3'd1) qtype_word[7:0] = b;
        if (tail_pos < TAIL_BYTES) tail_pos = tail_pos + 3'd1;
      end
      default: ;
    endcase

    res = '0;
    if (is_last) begin
      if (verdict_err != ST_OK) st = verdict_err;
      else if (walk_phase == PH_HEADER) st = ST_SHORT;
      else if (walk_phase == PH_TAIL && tail_pos >= TAIL_BYTES) st = ST_OK;
      else st = ST_INCOMPLETE;
      res.kind   = KIND_VERDICT;
      res.status = st;
      if (st == ST_OK) begin
        res.rr_type     = qtype_word;
        res.name_length = chars_kept;
      end
      pending_results.push_back(res);
      clear_parse_state();
    end else if (emit) begin
      res.kind      = KIND_CHAR;
      res.name_char = ch;
      pending_results.push_back(res);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Input monitor feeds the mirror on every accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready)
      parse_byte(in_bus.data_byte, in_bus.last_byte);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got_res.kind        = out_bus.kind;
      got_res.name_char   = out_bus.name_char;
      got_res.status      = out_bus.status;
      got_res.rr_type     = out_bus.rr_type;
      got_res.name_length = out_bus.name_length;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %p", got_res));
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.kind !== want_res.kind)
          report_mismatch($sformatf("kind got %0h want %0h", got_res.kind, want_res.kind));
        if (got_res.name_char !== want_res.name_char)
          report_mismatch($sformatf("name_char got %0h want %0h",
                                    got_res.name_char, want_res.name_char));
        if (got_res.status !== want_res.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    got_res.status, want_res.status));
        if (got_res.rr_type !== want_res.rr_type)
          report_mismatch($sformatf("rr_type got %0h want %0h",
                                    got_res.rr_type, want_res.rr_type));
        if (got_res.name_length !== want_res.name_length)
          report_mismatch($sformatf("name_length got %0d want %0d",
                                    got_res.name_length, want_res.name_length));
      end
    end
  end

  // Watchdog on cycles with no transaction anywhere
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("** dns_query_name_parser_top: FAILED **");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when requested
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len > 0) begin
        out_bus.ready <= 1'b0;
        repeat (rx_hold_len - 1) @(negedge clk_i);
        rx_hold_len = 0;
      end else begin
        stall = rx_stalls_on ? pick_gap() : 0;
        if (stall > 0) begin
          out_bus.ready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end else begin
          out_bus.ready <= 1'b1;
        end
      end
    end
  end

  // One input transaction; valid stays high into the next call when there is no gap
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= is_last;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    pkt_bytes.delete();
  endtask

  // Twelve header bytes with the question count in bytes 4 and 5
  task automatic put_header(input logic [7:0] qd_hi, input logic [7:0] qd_lo);
    for (int i = 0; i < 12; i++) begin
      if (i == 4) pkt_bytes.push_back(qd_hi);
      else if (i == 5) pkt_bytes.push_back(qd_lo);
      else pkt_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic put_label(input int len);
    pkt_bytes.push_back(8'(len));
    repeat (len) pkt_bytes.push_back(8'($urandom));
  endtask

  // Name terminator, type word and class
  task automatic put_tail(input logic [15:0] qtype);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(qtype[15:8]);
    pkt_bytes.push_back(qtype[7:0]);
    pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(8'($urandom));
  endtask

  // Header outcomes: short header, no questions, header alone
  task automatic test_header_cases();
    pkt_bytes.push_back(8'hFF);
    send_packet();
    put_header(8'h00, 8'h00);
    void'(pkt_bytes.pop_back());
    send_packet();
    put_header(8'h00, 8'h00);
    send_packet();
    put_header(8'h00, 8'h00);
    put_label(2);
    put_tail(16'h0001);
    send_packet();
    put_header(8'h00, 8'h01);
    send_packet();
  endtask

  // Name outcomes: root name, byte extremes, pointer, cut-off points, extra bytes
  task automatic test_name_cases();
    put_header(8'h01, 8'h00);
    put_tail(16'h0001);
    send_packet();
    put_header(8'hFF, 8'hFF);
    pkt_bytes.push_back(8'h01);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(8'h02);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h7F);
    put_tail(16'hFFFF);
    pkt_bytes.push_back(8'hAA);
    pkt_bytes.push_back(8'h55);
    send_packet();
    put_header(8'h00, 8'h01);
    put_label(3);
    pkt_bytes.push_back(8'hC0);
    pkt_bytes.push_back(8'h0C);
    put_tail(16'h0000);
    send_packet();
    put_header(8'h00, 8'h02);
    pkt_bytes.push_back(8'hFF);
    send_packet();
    // last byte falls on a name character
    put_header(8'h00, 8'h01);
    pkt_bytes.push_back(8'h03);
    pkt_bytes.push_back(8'h61);
    pkt_bytes.push_back(8'h62);
    send_packet();
    // ends inside the tail
    put_header(8'h00, 8'h01);
    put_label(1);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h1C);
    send_packet();
  endtask

  // Long name with single-top-bit lengths; the last dot falls past capacity
  task automatic test_truncation();
    put_header(8'h00, 8'h01);
    put_label(8'h80);
    put_label(8'h40);
    put_label(8'h7F);
    put_label(5);
    put_tail(16'h001C);
    send_packet();
  endtask

  // Receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_len = 200;
    put_header(8'h00, 8'h01);
    put_label(20);
    put_label(10);
    put_tail(16'h0005);
    send_packet();
    tx_idle_on = 1'b1;
  endtask

  task automatic make_random_packet();
    int variant;
    int labels;
    int len;
    int r;
    int cut;
    logic [7:0] hi;
    logic [7:0] lo;
    variant = $urandom_range(0, 99);
    if (variant < 8) begin
      // noise
      repeat ($urandom_range(1, 20)) pkt_bytes.push_back(8'($urandom));
      return;
    end
    r  = $urandom_range(0, 9);
    hi = (r < 3) ? 8'h00 : 8'($urandom);
    lo = (r >= 6) ? 8'h00 : 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      hi = 8'h00;
      lo = 8'h00;
    end else if (hi == 8'h00 && lo == 8'h00) begin
      lo = 8'h01;
    end
    put_header(hi, lo);
    labels = $urandom_range(0, 4);
    for (int i = 0; i < labels; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) len = $urandom_range(1, 12);
      else if (r < 98) len = $urandom_range(13, 63);
      else len = $urandom_range(64, 191);
      put_label(len);
    end
    if (variant < 18) begin
      // compression pointer in place of a length
      pkt_bytes.push_back(8'hC0 | 8'($urandom_range(0, 63)));
      repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
    end else begin
      put_tail(($urandom_range(0, 1) == 0) ? 16'h0001 : 16'($urandom));
      repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
    end
    if (variant >= 18 && variant < 33) begin
      cut = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endtask

  task automatic test_random_packets();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      tx_idle_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      make_random_packet();
      sent += pkt_bytes.size();
      send_packet();
    end
    tx_idle_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = '0;
    in_bus.last_byte = 1'b0;
    clear_parse_state();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_header_cases();
    test_name_cases();
    test_truncation();
    test_backpressure();
    test_random_packets();

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** dns_query_name_parser_top: PASSED **");
    end else begin
      $display("** dns_query_name_parser_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dqnp_pkg.sv
rtl/dqnp_if.sv
rtl/dqnp_parser.sv
rtl/dqnp_out_stage.sv
rtl/dns_query_name_parser_top.sv
sim/tb_dns_query_name_parser_top.sv
